// File: src/hkv_pkg.sv
`timescale 1ns / 1ps
package hkv_pkg;

  // Field widths
  localparam int KEY_W    = 37;
  localparam int STATUS_W = 2;

  // Table shape defaults
  localparam int DEF_BUCKETS = 256;
  localparam int DEF_WAYS    = 4;

  // Bucket reduction: key bits folded into the remainder per cycle
  localparam int HASH_BITS = 4;
  localparam int KEY_PAD   = ((KEY_W + HASH_BITS - 1) / HASH_BITS) * HASH_BITS;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  // One way of a bucket as held in the row memory
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic             value;
  } entry_t;

  // One request as it travels from front to back
  typedef struct packed {
    logic             cmd;
    logic [KEY_W-1:0] key;
    logic             value;
  } job_t;

  localparam int ENTRY_W = $bits(entry_t);
  localparam int JOB_W   = $bits(job_t);

endpackage

// File: src/hkv_if.sv
`timescale 1ns / 1ps
// Request channel
interface hkv_req_if import hkv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [KEY_W-1:0] hand_key;
  logic             new_value;

  modport source (output valid, cmd, hand_key, new_value, input ready);
  modport sink   (input valid, cmd, hand_key, new_value, output ready);
endinterface

// Response channel
interface hkv_rsp_if import hkv_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                read_value;

  modport source (output valid, status, read_value, input ready);
  modport sink   (input valid, status, read_value, output ready);
endinterface

// File: src/hashed_key_value_table.sv
`timescale 1ns / 1ps
// Channel  Dir  Fields
// req_i    in   cmd (1), hand_key (37), new_value (1)
// rsp_o    out  status (2), read_value (1)
//
// After reset a clearing pass writes every bucket row; no request is taken until it
// ends. The back end reads the bucket row, then compares ways and writes back, one
// request at a time. The front forms the bucket from the low key bits for a power-of-two
// BUCKETS, else by remainder reduction (4 key bits a cycle), which then sets the rate.
// A 2-entry queue parts front from back; the result register lets the back end fetch
// the next request while a response waits, and a held response then stalls the back.
module hashed_key_value_table import hkv_pkg::*; #(
  parameter int BUCKETS = DEF_BUCKETS,
  parameter int WAYS    = DEF_WAYS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hkv_req_if.sink   req_i,
  hkv_rsp_if.source rsp_o
);

  localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int QW    = IDX_W + JOB_W;

  logic          back_ready;
  logic          fq_push, fq_ready;
  logic [QW-1:0] fq_wdata, fq_rdata;
  logic          fq_valid, fq_pop;

  // Front: request intake and bucket selection
  hkv_front #(
    .BUCKETS (BUCKETS),
    .IDX_W   (IDX_W)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (back_ready),
    .req_i     (req_i),
    .q_ready_i (fq_ready),
    .q_valid_o (fq_push),
    .q_data_o  (fq_wdata)
  );

  // Queue between front and back
  hkv_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .wdata_i (fq_wdata),
    .full_no (fq_ready),
    .pop_i   (fq_pop),
    .valid_o (fq_valid),
    .rdata_o (fq_rdata)
  );

  // Back: bucket read-modify-write and response
  hkv_back #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS),
    .IDX_W   (IDX_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ready_o   (back_ready),
    .q_valid_i (fq_valid),
    .q_data_i  (fq_rdata),
    .q_pop_o   (fq_pop),
    .rsp_o     (rsp_o)
  );

endmodule

// File: src/hkv_ram.sv
`timescale 1ns / 1ps
module hkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port; read data holds when idle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/hkv_fifo.sv
`timescale 1ns / 1ps
module hkv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_no,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_no = (cnt_q != CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = slot_q[rptr_q];
  assign do_push = push_i && full_no;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill bookkeeping
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: src/hkv_front.sv
`timescale 1ns / 1ps
module hkv_front import hkv_pkg::*; #(
  parameter int BUCKETS = DEF_BUCKETS,
  parameter int IDX_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  hkv_req_if.sink                req_i,
  input  logic                   q_ready_i,
  output logic                   q_valid_o,
  output logic [IDX_W+JOB_W-1:0] q_data_o
);

  localparam bit POW2   = ((BUCKETS & (BUCKETS - 1)) == 0);
  localparam int NSTEPS = POW2 ? 1 : KEY_PAD / HASH_BITS;
  localparam int CNT_W  = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  job_t             job_q;
  logic [IDX_W-1:0] bucket;
  logic             last, push, accept;

  assign last        = (cnt_q == CNT_W'(NSTEPS - 1));
  assign push        = busy_q && last && q_ready_i;
  assign req_i.ready = en_i && (!busy_q || push);
  assign accept      = req_i.valid && req_i.ready;

  assign q_valid_o = busy_q && last;
  assign q_data_o  = {bucket, job_q};

  // Sequencing of the bucket reduction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (accept) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (push) begin
      busy_q <= 1'b0;
    end else if (busy_q && !last) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= '{cmd: req_i.cmd, key: req_i.hand_key, value: req_i.new_value};
    end
  end

  if (POW2) begin : g_mask
    // Power-of-two bucket count: the bucket is the low key bits
    assign bucket = IDX_W'(job_q.key & KEY_W'(BUCKETS - 1));
  end else begin : g_reduce
    // Remainder built MSB first, HASH_BITS key bits per cycle
    logic [KEY_PAD-1:0] sh_q;
    logic [IDX_W-1:0]   rem_q, rem_nxt;

    always_comb begin
      logic [IDX_W:0] acc;
      rem_nxt = rem_q;
      for (int i = 0; i < HASH_BITS; i++) begin
        acc = {rem_nxt, sh_q[KEY_PAD-1-i]};
        if (acc >= (IDX_W+1)'(BUCKETS)) begin
          acc = acc - (IDX_W+1)'(BUCKETS);
        end
        rem_nxt = acc[IDX_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (accept) begin
        sh_q  <= KEY_PAD'(req_i.hand_key);
        rem_q <= '0;
      end else if (busy_q && !last) begin
        sh_q  <= sh_q << HASH_BITS;
        rem_q <= rem_nxt;
      end
    end

    assign bucket = rem_nxt;
  end

endmodule

// File: src/hkv_back.sv
`timescale 1ns / 1ps
module hkv_back import hkv_pkg::*; #(
  parameter int BUCKETS = DEF_BUCKETS,
  parameter int WAYS    = DEF_WAYS,
  parameter int IDX_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  output logic                   ready_o,
  input  logic                   q_valid_i,
  input  logic [IDX_W+JOB_W-1:0] q_data_i,
  output logic                   q_pop_o,
  hkv_rsp_if.source              rsp_o
);

  localparam int ROW_W = WAYS * ENTRY_W;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] clr_q;
  job_t             job_q;
  logic [IDX_W-1:0] bkt_q;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata, wr_row;

  logic             hit, free, hit_val, fire, is_insert;
  logic [WAY_W-1:0] hit_way, free_way;

  logic             out_valid_q;
  status_e          status_q, status_d;
  logic             rv_q, rv_d;

  hkv_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS),
    .AW    (IDX_W)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (q_pop_o),
    .raddr_i (q_data_i[IDX_W+JOB_W-1:JOB_W]),
    .rdata_o (ram_rdata)
  );

  assign ready_o   = (state_q != S_CLEAR);
  assign q_pop_o   = (state_q == S_ISSUE) && q_valid_i;
  assign fire      = (state_q == S_EVAL) && (!out_valid_q || rsp_o.ready);
  assign is_insert = (job_q.cmd == CMD_INSERT);

  // Way search over the fetched bucket
  always_comb begin
    entry_t e;
    hit      = 1'b0;
    hit_way  = '0;
    hit_val  = 1'b0;
    free     = 1'b0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      e = entry_t'(ram_rdata[w*ENTRY_W +: ENTRY_W]);
      if (e.valid) begin
        if (!hit && (e.key == job_q.key)) begin
          hit     = 1'b1;
          hit_way = WAY_W'(w);
          hit_val = e.value;
        end
      end else if (!free) begin
        free     = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  // Updated bucket for an insert
  always_comb begin
    entry_t e;
    for (int w = 0; w < WAYS; w++) begin
      e = entry_t'(ram_rdata[w*ENTRY_W +: ENTRY_W]);
      if (hit && (hit_way == WAY_W'(w))) begin
        e.value = job_q.value;
      end else if (!hit && free && (free_way == WAY_W'(w))) begin
        e = '{valid: 1'b1, key: job_q.key, value: job_q.value};
      end
      wr_row[w*ENTRY_W +: ENTRY_W] = e;
    end
  end

  // Write port: clearing pass after reset, else write-back
  always_comb begin
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = fire && is_insert && (hit || free);
      ram_waddr = bkt_q;
      ram_wdata = wr_row;
    end
  end

  // Result
  always_comb begin
    rv_d = 1'b0;
    if (is_insert) begin
      status_d = (hit || free) ? STATUS_OK : STATUS_FULL;
    end else if (hit) begin
      status_d = STATUS_OK;
      rv_d     = hit_val;
    end else begin
      status_d = STATUS_MISS;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == IDX_W'(BUCKETS - 1)) begin
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (q_valid_i) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (fire) begin
          state_d = S_ISSUE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= job_t'(q_data_i[JOB_W-1:0]);
      bkt_q <= q_data_i[IDX_W+JOB_W-1:JOB_W];
    end
    if (fire) begin
      status_q <= status_d;
      rv_q     <= rv_d;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.read_value = rv_q;

endmodule

// File: bench/hkv_table_checker.sv
`timescale 1ns / 1ps
// Watches both channels, keeps a shadow of the bucket rows and checks
// every response against the result owed to the oldest open request.
module hkv_table_checker import hkv_pkg::*; #(
  parameter int BUCKETS = DEF_BUCKETS,
  parameter int WAYS    = DEF_WAYS
) (
  input  logic clk_i,
  input  logic rst_ni,
  hkv_req_if   req_i,
  hkv_rsp_if   rsp_i,
  output int   errors_o,
  output int   pending_o,
  output int   stored_o,
  output int   dropped_o,
  output int   found_o,
  output int   missed_o
);

  typedef struct packed {
    status_e status;
    logic    read_value;
  } result_t;

  // Shadow copy of the row memory, one entry per way
  entry_t  shadow_rows [BUCKETS][WAYS];
  result_t owed_results [$];

  // Apply one request to the shadow rows and return the result it owes
  function automatic result_t apply_request(logic cmd, logic [KEY_W-1:0] key, logic value);
    int unsigned row;
    int          hit;
    int          free_way;
    result_t     res;
    row      = int'(key % BUCKETS);
    hit      = -1;
    free_way = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (shadow_rows[row][w].valid) begin
        if (hit < 0 && shadow_rows[row][w].key == key) hit = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    res.status     = STATUS_OK;
    res.read_value = 1'b0;
    if (cmd == CMD_INSERT) begin
      if (hit >= 0) begin
        shadow_rows[row][hit].value = value;
      end else if (free_way >= 0) begin
        shadow_rows[row][free_way].valid = 1'b1;
        shadow_rows[row][free_way].key   = key;
        shadow_rows[row][free_way].value = value;
      end else begin
        res.status = STATUS_FULL;
      end
    end else begin
      if (hit >= 0) res.read_value = shadow_rows[row][hit].value;
      else          res.status     = STATUS_MISS;
    end
    return res;
  endfunction

  task automatic note_failure(string what);
    errors_o++;
    if (errors_o <= 10) $display("%0t: %s", $realtime, what);
  endtask

  // Responses are taken before requests, so a response can never be
  // matched to a request accepted on the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    result_t owed;
    result_t got;
    if (!rst_ni) begin
      for (int r = 0; r < BUCKETS; r++)
        for (int w = 0; w < WAYS; w++) shadow_rows[r][w] = '0;
      owed_results.delete();
      errors_o  = 0;
      pending_o = 0;
      stored_o  = 0;
      dropped_o = 0;
      found_o   = 0;
      missed_o  = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        got.status     = status_e'(rsp_i.status);
        got.read_value = rsp_i.read_value;
        if (owed_results.size() == 0) begin
          note_failure($sformatf("response with no open request: status %0d value %0b",
                                 got.status, got.read_value));
        end else begin
          owed = owed_results.pop_front();
          if (got.status !== owed.status || got.read_value !== owed.read_value)
            note_failure($sformatf("expected status %0d value %0b, got status %0d value %0b",
                                   owed.status, owed.read_value, rsp_i.status,
                                   rsp_i.read_value));
        end
      end
      if (req_i.valid && req_i.ready) begin
        owed = apply_request(req_i.cmd, req_i.hand_key, req_i.new_value);
        owed_results.push_back(owed);
        case (owed.status)
          STATUS_OK: begin
            if (req_i.cmd == CMD_INSERT) stored_o++;
            else                         found_o++;
          end
          STATUS_MISS: missed_o++;
          default:     dropped_o++;
        endcase
      end
      pending_o = owed_results.size();
    end
  end

endmodule

// File: bench/hashed_key_value_table_test.sv
`timescale 1ns / 1ps
module hashed_key_value_table_test;
  import hkv_pkg::*;

  localparam int BUCKETS = 256;
  localparam int WAYS    = 4;
  localparam int ROW_W   = $clog2(BUCKETS);
  localparam int TAG_W   = KEY_W - ROW_W;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int   req_idle_pct = 0;
  int   rsp_idle_pct = 0;
  logic hold_rsp     = 1'b0;
  int   sent         = 0;

  int   errors;
  int   pending;
  int   stored;
  int   dropped;
  int   found;
  int   missed;

  logic [TAG_W-1:0] hot_tag [6];
  logic [ROW_W-1:0] hot_row [8];

  hkv_req_if req_ch ();
  hkv_rsp_if rsp_ch ();

  always #5 clk_i = ~clk_i;

  hashed_key_value_table #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  hkv_table_checker #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_ch),
    .rsp_i     (rsp_ch),
    .errors_o  (errors),
    .pending_o (pending),
    .stored_o  (stored),
    .dropped_o (dropped),
    .found_o   (found),
    .missed_o  (missed)
  );

  // Response side: random stalls, or a long hold-off when asked
  initial rsp_ch.ready = 1'b0;
  always @(posedge clk_i) begin
    if (hold_rsp) rsp_ch.ready <= 1'b0;
    else          rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
  end

  // Offer one request, with random idle cycles ahead of it, and wait for it to go
  task automatic send_req(cmd_e cmd, logic [KEY_W-1:0] key, logic value);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.cmd       <= cmd;
    req_ch.hand_key  <= key;
    req_ch.new_value <= value;
    do @(posedge clk_i); while (!req_ch.ready);
    sent++;
  endtask

  // Stop offering until every open request has been answered
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic hold_results(int cycles);
    hold_rsp <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    hold_rsp <= 1'b0;
  endtask

  // Mostly keys from a few crowded buckets so rows fill and overflow;
  // the rest are arbitrary 37-bit patterns
  task automatic send_random(int count);
    logic [63:0]      wide;
    logic [KEY_W-1:0] key;
    cmd_e             cmd;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 85) begin
        key = {hot_tag[$urandom_range(0, 5)], hot_row[$urandom_range(0, 7)]};
      end else begin
        wide = {$urandom(), $urandom()};
        key  = wide[KEY_W-1:0];
      end
      cmd = ($urandom_range(0, 1) == 1) ? CMD_LOOKUP : CMD_INSERT;
      send_req(cmd, key, 1'($urandom_range(0, 1)));
    end
  endtask

  // Overall time limit
  initial begin
    #2ms;
    $display("hashed_key_value_table_test: done, errors");
    $finish;
  end

  initial begin
    req_ch.valid     = 1'b0;
    req_ch.cmd       = CMD_INSERT;
    req_ch.hand_key  = '0;
    req_ch.new_value = 1'b0;
    foreach (hot_tag[i]) hot_tag[i] = TAG_W'($urandom());
    foreach (hot_row[i]) hot_row[i] = ROW_W'($urandom());
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, overwrite, key extremes, full bucket
    send_req(CMD_LOOKUP, '0, 1'b1);
    send_req(CMD_INSERT, '0, 1'b1);
    send_req(CMD_LOOKUP, '0, 1'b0);
    send_req(CMD_INSERT, '0, 1'b0);
    send_req(CMD_LOOKUP, '0, 1'b1);
    send_req(CMD_INSERT, '1, 1'b1);
    send_req(CMD_LOOKUP, '1, 1'b0);
    send_req(CMD_INSERT, 37'd99999999999, 1'b1);
    send_req(CMD_LOOKUP, 37'd99999999999, 1'b0);
    for (int w = 0; w < WAYS; w++)
      send_req(CMD_INSERT, KEY_W'(5 + w * BUCKETS), 1'(w));
    send_req(CMD_INSERT, KEY_W'(5 + WAYS * BUCKETS), 1'b1);
    send_req(CMD_LOOKUP, KEY_W'(5 + WAYS * BUCKETS), 1'b0);
    send_req(CMD_INSERT, KEY_W'(5 + 2 * BUCKETS), 1'b1);
    send_req(CMD_LOOKUP, KEY_W'(5 + 2 * BUCKETS), 1'b0);
    send_req(CMD_LOOKUP, KEY_W'(5 + 3 * BUCKETS), 1'b0);
    send_req(CMD_LOOKUP, KEY_W'(6 + BUCKETS), 1'b1);
    drain_results();

    // Slow sender, slower receiver, with a long hold-off partway
    req_idle_pct <= 35;
    rsp_idle_pct <= 78;
    send_random(130);
    fork
      hold_results(60);
    join_none
    send_random(130);
    drain_results();

    // Slow sender, quicker receiver
    req_idle_pct <= 78;
    rsp_idle_pct <= 35;
    send_random(260);
    drain_results();

    // Full rate both ways, then a back-up against a stalled receiver
    req_idle_pct <= 0;
    rsp_idle_pct <= 0;
    send_random(130);
    fork
      hold_results(80);
    join_none
    send_random(130);
    drain_results();

    repeat (20) @(posedge clk_i);
    $display("Sent %0d requests: %0d stored, %0d dropped on a full bucket, %0d found, %0d missed",
             sent, stored, dropped, found, missed);
    $display("Idle mixes: 35/78, 78/35 and none, with two response hold-offs");
    if (errors == 0) begin
      $display("hashed_key_value_table_test: done, clean");
    end else begin
      $display("hashed_key_value_table_test: done, errors");
    end
    $finish;
  end

endmodule
